// ===== hdl/palette_sprite_blitter_macros.svh =====
// Assertion helpers shared by the blitter sources.
// Both macros expect a clock named i_clk and an active-low reset named i_rst_n.
`ifndef PALETTE_SPRITE_BLITTER_MACROS_SVH
`define PALETTE_SPRITE_BLITTER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PSB_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PSB_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/psb_pkg.sv =====
package psb_pkg;

    // Default geometry of the target screen and the palette.
    localparam int SCREEN_W_DEF      = 320;
    localparam int SCREEN_H_DEF      = 240;
    localparam int PALETTE_DEPTH_DEF = 128;

    // Field widths.
    localparam int COORD_W = 12;
    localparam int DIM_W   = 11;
    localparam int POS_W   = 11;
    localparam int IDX_W   = 8;
    localparam int COLOR_W = 16;
    localparam int ADDR_W  = 17;

    // Configuration port.
    localparam int APB_AW = 5;
    localparam int APB_DW = 32;

    // Depth of the queue between the front and back parts.
    localparam int QUEUE_DEPTH = 4;

    // Transparent-mode index limits.
    localparam logic [IDX_W-1:0] TRANSPARENT_INDEX = 8'd0;
    localparam logic [IDX_W-1:0] OPAQUE_LIMIT      = 8'd80;

    typedef enum logic {
        CMD_PAL_LOAD = 1'b0,
        CMD_PIXEL    = 1'b1
    } t_cmd;

    typedef enum logic [2:0] {
        REG_ORIGIN_X      = 3'd0,
        REG_ORIGIN_Y      = 3'd1,
        REG_SPRITE_WIDTH  = 3'd2,
        REG_SPRITE_HEIGHT = 3'd3,
        REG_ROW_PITCH     = 3'd4,
        REG_TRANSPARENT   = 3'd5,
        REG_MIRROR        = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic signed [COORD_W-1:0] origin_x;
        logic signed [COORD_W-1:0] origin_y;
        logic [DIM_W-1:0]          sprite_width;
        logic [DIM_W-1:0]          sprite_height;
        logic [DIM_W-1:0]          row_pitch;
        logic                      transparent_mode;
        logic                      mirror;
    } t_cfg;

    // One classified beat as handed from the front part to the back part.
    typedef struct packed {
        logic               is_load;
        logic               load_ok;
        logic [IDX_W-1:0]   index;
        logic [COLOR_W-1:0] value;
        logic               write;
        logic               bad;
        logic               last;
        logic [POS_W-1:0]   sx;
        logic [POS_W-1:0]   sy;
    } t_q_entry;

endpackage

// ===== hdl/psb_ifs.sv =====
// Input channel: palette loads and sprite bytes.
interface psb_in_if;
    logic                         valid;
    logic                         ready;
    logic                         cmd;
    logic [psb_pkg::IDX_W-1:0]    index;
    logic [psb_pkg::COLOR_W-1:0]  value;

    modport source (output valid, output cmd, output index, output value, input ready);
    modport sink   (input valid, input cmd, input index, input value, output ready);
endinterface

// Output channel: one framebuffer write record per input beat.
interface psb_out_if;
    logic                         valid;
    logic                         ready;
    logic                         write_enable;
    logic [psb_pkg::ADDR_W-1:0]   fb_addr;
    logic [psb_pkg::COLOR_W-1:0]  color;
    logic                         last;
    logic                         bad_index;

    modport source (output valid, output write_enable, output fb_addr, output color,
                    output last, output bad_index, input ready);
    modport sink   (input valid, input write_enable, input fb_addr, input color,
                    input last, input bad_index, output ready);
endinterface

// ===== hdl/psb_front.sv =====
module psb_front #(
    parameter int SCREEN_W      = psb_pkg::SCREEN_W_DEF,
    parameter int SCREEN_H      = psb_pkg::SCREEN_H_DEF,
    parameter int PALETTE_DEPTH = psb_pkg::PALETTE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  psb_pkg::t_cfg      i_cfg,
    psb_in_if.sink             i_in,
    input  logic               i_q_full,
    output logic               o_push,
    output psb_pkg::t_q_entry  o_entry
);

    localparam int DW = psb_pkg::DIM_W;
    localparam int SW = psb_pkg::COORD_W + 1;

    logic [DW-1:0] r_col, r_row;
    logic [DW-1:0] n_col, n_row;

    logic                 accept, is_pixel;
    logic [DW-1:0]        pitch, tx;
    logic                 empty, row_end, spr_end, in_col;
    logic signed [SW-1:0] sx, sy;
    logic                 on_screen, skip, in_pal, draw;

    // Take a beat whenever the queue has room.
    assign i_in.ready = !i_q_full;
    assign accept     = i_in.valid && !i_q_full;
    assign o_push     = accept;
    assign is_pixel   = (i_in.cmd == psb_pkg::CMD_PIXEL);

    // Geometry of the current source byte and its screen position.
    always_comb begin
        if (i_cfg.row_pitch == '0 || i_cfg.row_pitch < i_cfg.sprite_width) begin
            pitch = i_cfg.sprite_width;
        end else begin
            pitch = i_cfg.row_pitch;
        end
        empty   = (pitch == '0) || (i_cfg.sprite_height == '0);
        row_end = (r_col >= pitch - DW'(1));
        spr_end = row_end && (r_row >= i_cfg.sprite_height - DW'(1));
        in_col  = (r_col < i_cfg.sprite_width);
        tx      = i_cfg.mirror ? (i_cfg.sprite_width - DW'(1) - r_col) : r_col;
        sx      = {i_cfg.origin_x[psb_pkg::COORD_W-1], i_cfg.origin_x}
                  + $signed({2'b00, tx});
        sy      = {i_cfg.origin_y[psb_pkg::COORD_W-1], i_cfg.origin_y}
                  + $signed({2'b00, r_row});
        on_screen = !sx[SW-1] && (sx[SW-2:0] < (SW-1)'(SCREEN_W))
                 && !sy[SW-1] && (sy[SW-2:0] < (SW-1)'(SCREEN_H));
        skip    = i_cfg.transparent_mode
                  && (i_in.index == psb_pkg::TRANSPARENT_INDEX
                      || i_in.index >= psb_pkg::OPAQUE_LIMIT);
        in_pal  = ({1'b0, i_in.index} < 9'(PALETTE_DEPTH));
        draw    = !empty && in_col && on_screen && !skip;
    end

    // Classified beat for the back part.
    always_comb begin
        o_entry.is_load = !is_pixel;
        o_entry.load_ok = !is_pixel && in_pal;
        o_entry.index   = i_in.index;
        o_entry.value   = i_in.value;
        o_entry.write   = is_pixel && draw && in_pal;
        o_entry.bad     = is_pixel && draw && !in_pal;
        o_entry.last    = is_pixel && (empty || spr_end);
        o_entry.sx      = sx[psb_pkg::POS_W-1:0];
        o_entry.sy      = sy[psb_pkg::POS_W-1:0];
    end

    // Source column and row counters advance on every sprite byte.
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (accept && is_pixel) begin
            if (empty || spr_end) begin
                n_col = '0;
                n_row = '0;
            end else if (row_end) begin
                n_col = '0;
                n_row = r_row + DW'(1);
            end else begin
                n_col = r_col + DW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

// ===== hdl/psb_queue.sv =====
module psb_queue #(
    parameter int DEPTH = psb_pkg::QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  psb_pkg::t_q_entry  i_entry,
    output logic               o_full,
    input  logic               i_pop,
    output psb_pkg::t_q_entry  o_head,
    output logic               o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    psb_pkg::t_q_entry r_mem [DEPTH];
    logic [PW-1:0]     r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]     r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    // Pointers and fill count; the depth is a power of two so pointers wrap.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

// ===== hdl/psb_back.sv =====
module psb_back #(
    parameter int SCREEN_W      = psb_pkg::SCREEN_W_DEF,
    parameter int PALETTE_DEPTH = psb_pkg::PALETTE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  psb_pkg::t_q_entry  i_head,
    input  logic               i_q_empty,
    output logic               o_pop,
    psb_out_if.source          o_out
);

    localparam int PW     = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    localparam int PROD_W = psb_pkg::POS_W + 12;

    logic [psb_pkg::COLOR_W-1:0] r_palette [PALETTE_DEPTH];
    logic [psb_pkg::COLOR_W-1:0] r_rd_data;
    logic                        r_valid;
    logic                        r_we, r_last, r_bad;
    logic [psb_pkg::ADDR_W-1:0]  r_addr;
    logic [PROD_W-1:0]           n_addr;
    logic [PW-1:0]               pal_addr;

    // Pull the next beat when the output register is free or being drained.
    assign o_pop    = !i_q_empty && (!r_valid || o_out.ready);
    assign pal_addr = i_head.index[PW-1:0];
    assign n_addr   = PROD_W'(i_head.sy) * PROD_W'(SCREEN_W) + PROD_W'(i_head.sx);

    // Palette memory: loads write it, pixels read it, both in queue order.
    always_ff @(posedge i_clk) begin
        if (o_pop && i_head.load_ok) begin
            r_palette[pal_addr] <= i_head.value;
        end
        if (o_pop) begin
            r_rd_data <= r_palette[pal_addr];
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_we   <= i_head.write;
            r_last <= i_head.last;
            r_bad  <= i_head.bad;
            r_addr <= i_head.write ? n_addr[psb_pkg::ADDR_W-1:0] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    assign o_out.valid        = r_valid;
    assign o_out.write_enable = r_we;
    assign o_out.fb_addr      = r_addr;
    assign o_out.color        = r_we ? r_rd_data : '0;
    assign o_out.last         = r_last;
    assign o_out.bad_index    = r_bad;

endmodule

// ===== hdl/palette_sprite_blitter.sv =====
// Palette sprite blitter. Palette loads and 8-bit sprite bytes arrive on the
// input channel in source raster order; every input beat yields exactly one
// output beat, carrying a framebuffer write (address row * SCREEN_W + column,
// RGB565 color) or a no-write record with the last and bad_index flags. The
// block takes one beat per clock cycle when the output side keeps up; an
// accepted beat is stored in the queue and then in the output register before
// it is offered on the output. The front part handles the source counters,
// clipping and transparency in the accepting cycle, a four-entry queue
// follows, and the back part performs the single-port palette read and the
// address multiply before the output register. Palette entries must be
// loaded before a pixel uses them. Registers are written over the APB port
// at byte address 4 * index; the user must write them only while no beat is
// in flight, which the block itself does not enforce.
`include "palette_sprite_blitter_macros.svh"

module palette_sprite_blitter #(
    parameter int SCREEN_W      = psb_pkg::SCREEN_W_DEF,
    parameter int SCREEN_H      = psb_pkg::SCREEN_H_DEF,
    parameter int PALETTE_DEPTH = psb_pkg::PALETTE_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [psb_pkg::APB_AW-1:0]  paddr,
    input  logic [psb_pkg::APB_DW-1:0]  pwdata,
    output logic [psb_pkg::APB_DW-1:0]  prdata,
    output logic                        pready,
    psb_in_if.sink                      i_in,
    psb_out_if.source                   o_out
);

    psb_pkg::t_cfg      r_cfg;
    psb_pkg::t_q_entry  q_in, q_head;
    psb_pkg::t_reg_idx  reg_idx;
    logic               q_push, q_pop, q_full, q_empty;
    logic               cfg_wr;

    // Configuration registers.
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = psb_pkg::t_reg_idx'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                psb_pkg::REG_ORIGIN_X:      r_cfg.origin_x <= $signed(pwdata[11:0]);
                psb_pkg::REG_ORIGIN_Y:      r_cfg.origin_y <= $signed(pwdata[11:0]);
                psb_pkg::REG_SPRITE_WIDTH:  r_cfg.sprite_width <= pwdata[10:0];
                psb_pkg::REG_SPRITE_HEIGHT: r_cfg.sprite_height <= pwdata[10:0];
                psb_pkg::REG_ROW_PITCH:     r_cfg.row_pitch <= pwdata[10:0];
                psb_pkg::REG_TRANSPARENT:   r_cfg.transparent_mode <= pwdata[0];
                psb_pkg::REG_MIRROR:        r_cfg.mirror <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        unique case (reg_idx)
            psb_pkg::REG_ORIGIN_X:      prdata = 32'({r_cfg.origin_x});
            psb_pkg::REG_ORIGIN_Y:      prdata = 32'({r_cfg.origin_y});
            psb_pkg::REG_SPRITE_WIDTH:  prdata = 32'(r_cfg.sprite_width);
            psb_pkg::REG_SPRITE_HEIGHT: prdata = 32'(r_cfg.sprite_height);
            psb_pkg::REG_ROW_PITCH:     prdata = 32'(r_cfg.row_pitch);
            psb_pkg::REG_TRANSPARENT:   prdata = 32'(r_cfg.transparent_mode);
            psb_pkg::REG_MIRROR:        prdata = 32'(r_cfg.mirror);
            default:                    prdata = '0;
        endcase
    end

    psb_front #(
        .SCREEN_W      (SCREEN_W),
        .SCREEN_H      (SCREEN_H),
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_entry  (q_in)
    );

    psb_queue #(
        .DEPTH (psb_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_empty (q_empty)
    );

    psb_back #(
        .SCREEN_W      (SCREEN_W),
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_head    (q_head),
        .i_q_empty (q_empty),
        .o_pop     (q_pop),
        .o_out     (o_out)
    );

    // A write and a bad-index flag never share a beat; no-write beats carry zeros.
    `PSB_ASSERT_NOW(a_no_write_fields, o_out.valid && !o_out.write_enable, o_out.fb_addr == '0 && o_out.color == '0, "no-write beat carries a nonzero address or color")
    `PSB_ASSERT_NOW(a_write_not_bad, o_out.valid && o_out.write_enable, !o_out.bad_index, "beat flags both a write and a bad index")
    // A stalled output register must hold back the queue.
    `PSB_ASSERT_NOW(a_stall_no_pop, o_out.valid && !o_out.ready, !q_pop, "queue popped while the output beat is stalled")
    // An accepted beat is in the queue in the next cycle.
    `PSB_ASSERT_NEXT(a_push_lands, i_in.valid && i_in.ready, !q_empty, "accepted beat missing from the queue")

endmodule
